// File: design/metropolis_orbital_sampler_step_unit_assert.svh
// Assertion macros shared by the sampler step checker.
// No dependencies.
`ifndef METROPOLIS_ORBITAL_SAMPLER_STEP_UNIT_ASSERT_SVH
`define METROPOLIS_ORBITAL_SAMPLER_STEP_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define MOSS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define MOSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// File: design/moss_pkg.sv
// Package for the Metropolis orbital sampler step unit.
// Holds register indexes, the exponential table and shared types.
package moss_pkg;
   localparam int unsigned CsrAddrWidth = 5;
   localparam logic [2:0] RegMode   = 3'd0;
   localparam logic [2:0] RegWidth  = 3'd1;
   localparam logic [2:0] RegStartX = 3'd2;
   localparam logic [2:0] RegStartY = 3'd3;
   localparam logic [2:0] RegStartZ = 3'd4;
   localparam logic [30:0] Log2eQ30 = 31'd1549082005;
   localparam logic signed [33:0] ExpClamp = 34'sd134217728;

   typedef struct packed {
      logic signed [15:0] noise_x;
      logic signed [15:0] noise_y;
      logic signed [15:0] noise_z;
      logic [15:0]        uniform_draw;
   } req_type;

   typedef struct packed {
      logic               accepted;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [31:0]        total_steps;
      logic [31:0]        accepted_steps;
   } rsp_type;

   // Start and done strobes for a square root unit.
   typedef struct packed {
      logic start;
      logic done;
   } sqrt_ctl_type;

   // 2^(k/16) in Q2.16.
   function automatic logic [17:0] pow2_tab(input logic [4:0] k);
      logic [17:0] v;
      begin
         case (k)
            5'd0: v = 18'd65536;   5'd1: v = 18'd68438;  5'd2: v = 18'd71468;
            5'd3: v = 18'd74632;   5'd4: v = 18'd77936;  5'd5: v = 18'd81386;
            5'd6: v = 18'd84990;   5'd7: v = 18'd88752;  5'd8: v = 18'd92682;
            5'd9: v = 18'd96785;   5'd10: v = 18'd101070; 5'd11: v = 18'd105545;
            5'd12: v = 18'd110218; 5'd13: v = 18'd115098; 5'd14: v = 18'd120194;
            5'd15: v = 18'd125515; default: v = 18'd131072;
         endcase
         return v;
      end
   endfunction
endpackage

// File: design/moss_stream_if.sv
// Valid/ready channel interface carrying one payload type.
// The payload type is a parameter; no package dependency.
interface moss_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: design/metropolis_orbital_sampler_step_unit.sv
// Metropolis orbital sampler step: one walker step per transaction.
// One item at a time: a new request is taken the cycle after the result
// transaction, and the time per item is set mostly by the 32-iteration
// square root lanes that run the two radii in parallel.
// Reset (synchronous) restores registers, the start position and zero counts.
module metropolis_orbital_sampler_step_unit (
   input  logic clock,
   input  logic reset,
   moss_stream_if.sink   req,
   moss_stream_if.source rsp,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [moss_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import moss_pkg::*;

   typedef enum logic [1:0] {IDLE, PROP, ROOTS, DECIDE} state_type;

   state_type          state_ff, state_in;
   logic               mode_ff;
   logic [15:0]        width_ff;
   logic signed [31:0] sx_ff, sy_ff, sz_ff;
   logic signed [31:0] wx_ff, wy_ff, wz_ff;
   logic signed [31:0] nx_ff, ny_ff, nz_ff;
   logic [15:0]        u_ff;
   logic [31:0]        steps_ff, accs_ff;
   logic [31:0]        rn_ff, ro_ff;
   logic               nd_ff, od_ff;
   logic               rv_ff;
   rsp_type            rsp_ff;
   logic               lane_start, n_done, o_done;
   logic [31:0]        root_n, root_o;
   logic               dec_start, dec_done, dec_acc;
   logic               wr;
   logic [2:0]         reg_idx;

   function automatic logic signed [31:0] propose(input logic signed [31:0] p,
                                                  input logic [15:0] w,
                                                  input logic signed [15:0] q);
      logic signed [32:0] prod;
      logic signed [33:0] s;
      begin
         prod = signed'({1'b0, w}) * q;
         s    = 34'(p) + 34'(prod >>> 4);
         if (s > 34'sd2147483647) s = 34'sd2147483647;
         if (s < -34'sd2147483648) s = -34'sd2147483648;
         return s[31:0];
      end
   endfunction

   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[4:2];
   assign csr_pready = 1'b1;
   assign req.ready  = (state_ff == IDLE) && !rv_ff;
   assign rsp.valid  = rv_ff;
   assign rsp.data   = rsp_ff;
   assign lane_start = (state_ff == PROP);
   assign dec_start  = (state_ff == ROOTS) && nd_ff && od_ff;

   // Register read-back.
   always_comb begin
      unique case (reg_idx)
         RegMode:   csr_prdata = {31'd0, mode_ff};
         RegWidth:  csr_prdata = {16'd0, width_ff};
         RegStartX: csr_prdata = sx_ff;
         RegStartY: csr_prdata = sy_ff;
         RegStartZ: csr_prdata = sz_ff;
         default:   csr_prdata = '0;
      endcase
   end

   // Two lanes: proposed and current radius.
   moss_sqrt_lane u_lane_n (.clock, .reset, .start(lane_start), .px(nx_ff), .py(ny_ff),
                            .pz(nz_ff), .done(n_done), .root(root_n));
   moss_sqrt_lane u_lane_o (.clock, .reset, .start(lane_start), .px(wx_ff), .py(wy_ff),
                            .pz(wz_ff), .done(o_done), .root(root_o));

   moss_decide u_decide (.clock, .reset, .start(dec_start), .mode(mode_ff),
                         .r_new(rn_ff), .r_old(ro_ff), .z_new(nz_ff), .z_old(wz_ff),
                         .u(u_ff), .done(dec_done), .accept(dec_acc));

   // Step sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         IDLE:    if (req.valid && req.ready) state_in = PROP;
         PROP:    state_in = ROOTS;
         ROOTS:   if (nd_ff && od_ff) state_in = DECIDE;
         DECIDE:  if (dec_done) state_in = IDLE;
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         mode_ff  <= 1'b0;
         width_ff <= 16'd307;
         sx_ff <= '0; sy_ff <= '0; sz_ff <= 32'sd65536;
         wx_ff <= '0; wy_ff <= '0; wz_ff <= 32'sd65536;
         steps_ff <= '0; accs_ff <= '0;
         rv_ff <= 1'b0; nd_ff <= 1'b0; od_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (wr) begin
            unique case (reg_idx)
               RegMode:   mode_ff <= csr_pwdata[0];
               RegWidth:  width_ff <= csr_pwdata[15:0];
               RegStartX: begin sx_ff <= csr_pwdata; wx_ff <= csr_pwdata; end
               RegStartY: begin sy_ff <= csr_pwdata; wy_ff <= csr_pwdata; end
               RegStartZ: begin sz_ff <= csr_pwdata; wz_ff <= csr_pwdata; end
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) rv_ff <= 1'b0;
         if (state_ff == PROP) begin nd_ff <= 1'b0; od_ff <= 1'b0; end
         if (n_done) nd_ff <= 1'b1;
         if (o_done) od_ff <= 1'b1;
         if (state_ff == DECIDE && dec_done) begin
            if (dec_acc) begin
               wx_ff <= nx_ff; wy_ff <= ny_ff; wz_ff <= nz_ff;
               if (accs_ff != '1) accs_ff <= accs_ff + 32'd1;
            end
            if (steps_ff != '1) steps_ff <= steps_ff + 32'd1;
            rv_ff <= 1'b1;
         end
      end
      // The proposal is formed as the request is taken, so the lanes see it at once.
      if (req.valid && req.ready) begin
         nx_ff <= propose(wx_ff, width_ff, req.data.noise_x);
         ny_ff <= propose(wy_ff, width_ff, req.data.noise_y);
         nz_ff <= propose(wz_ff, width_ff, req.data.noise_z);
         u_ff  <= req.data.uniform_draw;
      end
      if (n_done) rn_ff <= root_n;
      if (o_done) ro_ff <= root_o;
      if (state_ff == DECIDE && dec_done) begin
         rsp_ff.accepted       <= dec_acc;
         rsp_ff.pos_x          <= dec_acc ? nx_ff : wx_ff;
         rsp_ff.pos_y          <= dec_acc ? ny_ff : wy_ff;
         rsp_ff.pos_z          <= dec_acc ? nz_ff : wz_ff;
         rsp_ff.total_steps    <= (steps_ff != '1) ? steps_ff + 32'd1 : steps_ff;
         rsp_ff.accepted_steps <= (dec_acc && accs_ff != '1) ? accs_ff + 32'd1 : accs_ff;
      end
   end
endmodule

// File: design/moss_sqrt_lane.sv
// One lane: squares a position, sums and takes an iterative root of the 64-bit sum.
// Depends on moss_pkg; one bit of root is resolved per cycle.
module moss_sqrt_lane (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] px,
   input  logic signed [31:0] py,
   input  logic signed [31:0] pz,
   output logic               done,
   output logic [31:0]        root
);
   import moss_pkg::*;

   typedef enum logic [1:0] {IDLE, SQX, SQY, ROOT} state_type;

   state_type   state_ff, state_in;
   logic [63:0] acc_ff, acc_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] res_ff, res_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        done_ff, done_in;
   logic [31:0] mag;
   logic [63:0] sq;
   logic [33:0] trial;
   logic [33:0] part;

   // Select the coordinate squared in this cycle.
   always_comb begin
      unique case (state_ff)
         SQX:     mag = px[31] ? 32'(-px) : 32'(px);
         SQY:     mag = py[31] ? 32'(-py) : 32'(py);
         default: mag = pz[31] ? 32'(-pz) : 32'(pz);
      endcase
      sq = 64'(mag) * 64'(mag);
   end

   // Sum the squares, then restoring root: bring down two bits of the radicand each cycle.
   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      res_in   = res_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      part     = {rem_ff, acc_ff[63:62]};
      trial    = {res_ff, 2'b01};
      unique case (state_ff)
         IDLE: if (start) begin
            acc_in   = sq;
            state_in = SQX;
         end
         SQX: begin
            acc_in   = acc_ff + sq;
            state_in = SQY;
         end
         SQY: begin
            acc_in   = acc_ff + sq;
            state_in = ROOT;
            rem_in   = '0;
            res_in   = '0;
            cnt_in   = '0;
         end
         ROOT: begin
            // acc_ff holds the 64-bit sum; the root takes 32 iterations.
            acc_in = {acc_ff[61:0], 2'b00};
            if (part >= trial) begin
               rem_in = 32'(part - trial);
               res_in = {res_ff[30:0], 1'b1};
            end else begin
               rem_in = 32'(part);
               res_in = {res_ff[30:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = IDLE;
               done_in  = 1'b1;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      res_ff <= res_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign root = res_ff;
endmodule

// File: design/moss_decide.sv
// Accept decision: exponent, mantissa and exact accept comparison.
// Depends on moss_pkg for constants and the power-of-two table.
module moss_decide (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               mode,
   input  logic [31:0]        r_new,
   input  logic [31:0]        r_old,
   input  logic signed [31:0] z_new,
   input  logic signed [31:0] z_old,
   input  logic [15:0]        u,
   output logic               done,
   output logic               accept
);
   import moss_pkg::*;

   typedef enum logic [2:0] {IDLE, EXPO, MANT, MUL, CMP} state_type;

   state_type          state_ff, state_in;
   logic signed [33:0] e_ff, e_in;
   logic signed [65:0] g_ff, g_in;
   logic [17:0]        m_ff, m_in;
   logic [63:0]        zo2_ff, zo2_in, zn2_ff, zn2_in;
   logic [81:0]        lhs_ff, lhs_in, rhs_ff, rhs_in;
   logic               done_ff, done_in, acc_ff, acc_in;
   logic [31:0]        zo_mag, zn_mag;
   logic signed [33:0] ediff, eclamp;
   logic signed [49:0] n;
   logic [15:0]        f;
   logic [4:0]         idx;
   logic [17:0]        t0, t1;
   logic [29:0]        dm;
   logic [7:0]         bl, br;
   logic [7:0]         sh;
   logic [161:0]       shifted;

   function automatic logic [7:0] bitlen(input logic [81:0] v);
      logic [7:0] r;
      begin
         r = '0;
         for (int i = 0; i < 82; i++) if (v[i]) r = 8'(i + 1);
         return r;
      end
   endfunction

   always_comb begin
      zo_mag = z_old[31] ? 32'(-z_old) : 32'(z_old);
      zn_mag = z_new[31] ? 32'(-z_new) : 32'(z_new);
      ediff  = 34'(signed'({2'b00, r_new})) - 34'(signed'({2'b00, r_old}));
      if (!mode) ediff = ediff <<< 1;
      eclamp = ediff;
      if (ediff > ExpClamp) eclamp = ExpClamp;
      if (ediff < -ExpClamp) eclamp = -ExpClamp;
      n   = 50'(g_ff >>> 46);
      f   = g_ff[45:30];
      idx = {1'b0, f[15:12]};
      t0  = pow2_tab(idx);
      t1  = pow2_tab(idx + 5'd1);
      dm  = 30'(t1 - t0) * 30'(f[11:0]);
      bl  = bitlen(lhs_ff);
      br  = bitlen(rhs_ff);
      sh  = n[49] ? 8'(-n) : ((n > 50'sd200) ? 8'd200 : 8'(n));
      shifted = n[49] ? (162'(lhs_ff) << sh) : (162'(rhs_ff) << sh);
   end

   always_comb begin
      state_in = state_ff;
      e_in = e_ff; g_in = g_ff; m_in = m_ff;
      zo2_in = zo2_ff; zn2_in = zn2_ff;
      lhs_in = lhs_ff; rhs_in = rhs_ff;
      done_in = 1'b0; acc_in = acc_ff;
      unique case (state_ff)
         IDLE: if (start) begin
            e_in   = eclamp;
            zo2_in = mode ? 64'(zo_mag) * 64'(zo_mag) : 64'd1;
            zn2_in = mode ? 64'(zn_mag) * 64'(zn_mag) : 64'd1;
            state_in = EXPO;
         end
         EXPO: begin
            // -e * log2(e) in Q2.30 keeps 30 extra fraction bits.
            g_in = 66'(-e_ff) * 66'(signed'({1'b0, Log2eQ30}));
            state_in = MANT;
         end
         MANT: begin
            m_in = t0 + 18'(dm >> 12);
            state_in = MUL;
         end
         MUL: begin
            lhs_in = 82'(zo2_ff) * 82'(u);
            rhs_in = 82'(zn2_ff) * 82'(m_ff);
            state_in = CMP;
         end
         CMP: begin
            if (mode && zo2_ff == 64'd0) acc_in = 1'b1;
            else if (!n[49]) begin
               if (rhs_ff != '0 && 50'(br) + n > 50'sd80) acc_in = 1'b1;
               else acc_in = 162'(lhs_ff) <= shifted;
            end else begin
               if (lhs_ff == '0) acc_in = 1'b1;
               else if (50'(bl) - n > 50'sd80) acc_in = 1'b0;
               else acc_in = shifted <= 162'(rhs_ff);
            end
            done_in  = 1'b1;
            state_in = IDLE;
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      e_ff <= e_in; g_ff <= g_in; m_ff <= m_in;
      zo2_ff <= zo2_in; zn2_ff <= zn2_in;
      lhs_ff <= lhs_in; rhs_ff <= rhs_in; acc_ff <= acc_in;
   end

   assign done   = done_ff;
   assign accept = acc_ff;
endmodule

// File: design/moss_checker.sv
// Port checker for the sampler step unit, bound to the top level.
// Depends on moss_pkg and the assertion macro header.
`include "metropolis_orbital_sampler_step_unit_assert.svh"
module moss_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input moss_pkg::rsp_type   rsp_data
);
   import moss_pkg::*;

   // A pending result holds until taken.
   `MOSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   // One transaction at a time: no new request while a result is pending.
   `MOSS_ASSERT_IMP(a_no_overlap, clock, reset, rsp_valid, !req_ready)
   // Accepted count never exceeds total count.
   `MOSS_ASSERT_IMP(a_count_order, clock, reset, rsp_valid, rsp_data.accepted_steps <= rsp_data.total_steps)
   // A request is followed by busy, not an immediate result.
   `MOSS_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready && !rsp_valid)
endmodule

bind metropolis_orbital_sampler_step_unit moss_checker u_moss_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data));
